### design/lav_pkg.sv
// ============================================================================
// lav_pkg
// Shared types, constants and latency helpers of the look-at view matrix block.
// ============================================================================
package lav_pkg;

    // default fixed-point format
    localparam int LAV_FRAC_BITS = 16;
    localparam int LAV_WORD_BITS = 32;

    // stream widths
    localparam int LAV_FIELD_W = 32;
    localparam int LAV_IN_W    = 9 * LAV_FIELD_W;
    localparam int LAV_OUT_W   = 4 * LAV_FIELD_W;
    localparam int LAV_USER_W  = 3;

    // column index of the translation column, marked as last
    localparam logic [1:0] LAV_LAST_COL = 2'd3;

    // the largest block-scaled magnitude lies in [2^29, 2^30)
    localparam int LAV_NORM_W = 30;

    // root and divide units: steps per stage, root stages over a 64-bit sum
    localparam int LAV_STEPS  = 4;
    localparam int LAV_SQ_STG = 8;

    typedef logic signed [LAV_FIELD_W-1:0] t_word;

    // divider stages for FRAC_BITS+1 quotient bits
    function automatic int lav_div_stg(input int frac);
        return (frac + LAV_STEPS) >> 2;
    endfunction

    // input-to-output register count of the normalize unit
    function automatic int lav_norm_lat(input int frac);
        return 5 + LAV_SQ_STG + 2 + lav_div_stg(frac);
    endfunction

endpackage

### design/look_at_view_matrix.sv
// ============================================================================
// look_at_view_matrix
// Output: the four column words of a camera leave one per cycle while
// m_axis_tready is high. The whole pipeline stalls while a matrix goes out, so
// a new camera is taken only when the output is empty or its last column leaves.
// Reset: synchronous, active low; clears all valid bits and the column count.
// ============================================================================
module look_at_view_matrix
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = LAV_FRAC_BITS,
    parameter int WORD_BITS = LAV_WORD_BITS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
    input  logic [LAV_IN_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // row0_value, row1_value, row2_value, row3_value
    output logic [LAV_OUT_W-1:0]  m_axis_tdata,
    // column_index[1:0], degenerate[2]
    output logic [LAV_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int L   = lav_norm_lat(FRAC_BITS);
    localparam int UW  = FRAC_BITS + 2;
    localparam int VW  = FRAC_BITS + 3;
    localparam int PUN = 2 * UW;
    localparam int PUE = UW + 32;
    localparam int PVE = VW + 32;

    // half away from zero, shift by FRAC_BITS
    function automatic logic signed [39:0] rnd(input logic signed [67:0] x);
        logic [67:0] mag;
        logic [67:0] q;
        mag = x[67] ? 68'(-x) : 68'(x);
        q   = (mag + (68'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return x[67] ? -$signed(q[39:0]) : $signed(q[39:0]);
    endfunction

    // clamp to the signed WORD_BITS range, keep the low 32 bits
    function automatic t_word sat(input logic signed [39:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        logic signed [65:0] xx;
        hi = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
        lo = -hi - 66'sd1;
        xx = 66'(x);
        if (xx > hi) xx = hi;
        if (xx < lo) xx = lo;
        return xx[31:0];
    endfunction

    logic w_adv;

    // ---------------- stage 1: difference center - eye
    t_word              w_in [9];
    logic               r1_vld;
    logic signed [32:0] r1_d  [3];
    t_word              r1_up [3];
    t_word              r1_e  [3];

    always_comb begin
        for (int k = 0; k < 9; k++) w_in[k] = s_axis_tdata[k*LAV_FIELD_W +: LAV_FIELD_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i]  <= 33'(w_in[3+i]) - 33'(w_in[i]);
                r1_up[i] <= w_in[6+i];
                r1_e[i]  <= w_in[i];
            end
        end
    end

    // ---------------- stage 2: cross products, forward magnitudes
    logic signed [63:0] r2_p [6];
    logic [31:0]        r2_dmag [3];
    logic [2:0]         r2_dneg;
    t_word              r2_e [3];
    logic               r2_vld;
    logic signed [32:0] w2_dabs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) w2_dabs[i] = r1_d[i][32] ? -r1_d[i] : r1_d[i];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_p[0] <= 64'(r1_d[1]) * 64'(r1_up[2]);
            r2_p[1] <= 64'(r1_d[2]) * 64'(r1_up[1]);
            r2_p[2] <= 64'(r1_d[2]) * 64'(r1_up[0]);
            r2_p[3] <= 64'(r1_d[0]) * 64'(r1_up[2]);
            r2_p[4] <= 64'(r1_d[0]) * 64'(r1_up[1]);
            r2_p[5] <= 64'(r1_d[1]) * 64'(r1_up[0]);
            for (int i = 0; i < 3; i++) begin
                r2_dmag[i] <= w2_dabs[i][31:0];
                r2_dneg[i] <= r1_d[i][32];
            end
            r2_e <= r1_e;
        end
    end

    // ---------------- stage 3: side vector as sign and magnitude
    logic signed [64:0] w3_diff [3];
    logic [63:0]        r3_cmag [3];
    logic [2:0]         r3_cneg;
    logic [31:0]        r3_dmag [3];
    logic [2:0]         r3_dneg;
    t_word              r3_e [3];
    logic               r3_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w3_diff[i] = 65'(r2_p[2*i]) - 65'(r2_p[2*i+1]);
            if (w3_diff[i][64]) w3_diff[i] = -w3_diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r3_cmag[i] <= w3_diff[i][63:0];
                r3_cneg[i] <= 65'(r2_p[2*i]) < 65'(r2_p[2*i+1]);
            end
            r3_dmag <= r2_dmag;
            r3_dneg <= r2_dneg;
            r3_e    <= r2_e;
        end
    end

    // ---------------- normalize units, eye and valid ride alongside
    logic signed [UW-1:0] w_n [3];
    logic signed [UW-1:0] w_u [3];
    logic                 w_n_nz;
    logic                 w_u_nz;
    t_word                r_dl_e   [L][3];
    logic                 r_dl_vld [L];

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (32)
    ) u_norm_fwd (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_mag  (r3_dmag),
        .i_neg  (r3_dneg),
        .o_unit (w_n),
        .o_nz   (w_n_nz)
    );

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (64)
    ) u_norm_side (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_mag  (r3_cmag),
        .i_neg  (r3_cneg),
        .o_unit (w_u),
        .o_nz   (w_u_nz)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl_e[0] <= r3_e;
            for (int s = 1; s < L; s++) r_dl_e[s] <= r_dl_e[s-1];
        end
    end

    // ---------------- stage 4: products for v and dot products with eye
    logic signed [PUN-1:0] r4_un [6];
    logic signed [PUE-1:0] r4_ue [3];
    logic signed [PUE-1:0] r4_ne [3];
    logic signed [UW-1:0]  r4_u [3];
    logic signed [UW-1:0]  r4_n [3];
    t_word                 r4_e [3];
    logic                  r4_ok;
    logic                  r4_vld;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_un[0] <= PUN'(w_u[1]) * PUN'(w_n[2]);
            r4_un[1] <= PUN'(w_u[2]) * PUN'(w_n[1]);
            r4_un[2] <= PUN'(w_u[2]) * PUN'(w_n[0]);
            r4_un[3] <= PUN'(w_u[0]) * PUN'(w_n[2]);
            r4_un[4] <= PUN'(w_u[0]) * PUN'(w_n[1]);
            r4_un[5] <= PUN'(w_u[1]) * PUN'(w_n[0]);
            for (int i = 0; i < 3; i++) begin
                r4_ue[i] <= PUE'(w_u[i]) * PUE'(r_dl_e[L-1][i]);
                r4_ne[i] <= PUE'(w_n[i]) * PUE'(r_dl_e[L-1][i]);
            end
            r4_u  <= w_u;
            r4_n  <= w_n;
            r4_e  <= r_dl_e[L-1];
            r4_ok <= w_n_nz & w_u_nz;
        end
    end

    // ---------------- stage 5: v, first and third translation
    logic signed [VW-1:0] r5_v [3];
    logic signed [39:0]   r5_t0;
    logic signed [39:0]   r5_t2;
    logic signed [39:0]   w5_v [3];
    logic signed [UW-1:0] r5_u [3];
    logic signed [UW-1:0] r5_n [3];
    t_word                r5_e [3];
    logic                 r5_ok;
    logic                 r5_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) w5_v[i] = rnd(68'(r4_un[2*i]) - 68'(r4_un[2*i+1]));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) r5_v[i] <= w5_v[i][VW-1:0];
            r5_t0 <= rnd(-(68'(r4_ue[0]) + 68'(r4_ue[1]) + 68'(r4_ue[2])));
            r5_t2 <= rnd(68'(r4_ne[0]) + 68'(r4_ne[1]) + 68'(r4_ne[2]));
            r5_u  <= r4_u;
            r5_n  <= r4_n;
            r5_e  <= r4_e;
            r5_ok <= r4_ok;
        end
    end

    // ---------------- stage 6: v dot eye products
    logic signed [PVE-1:0] r6_ve [3];
    logic signed [VW-1:0]  r6_v [3];
    logic signed [39:0]    r6_t0;
    logic signed [39:0]    r6_t2;
    logic signed [UW-1:0]  r6_u [3];
    logic signed [UW-1:0]  r6_n [3];
    logic                  r6_ok;
    logic                  r6_vld;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) r6_ve[i] <= PVE'(r5_v[i]) * PVE'(r5_e[i]);
            r6_v  <= r5_v;
            r6_t0 <= r5_t0;
            r6_t2 <= r5_t2;
            r6_u  <= r5_u;
            r6_n  <= r5_n;
            r6_ok <= r5_ok;
        end
    end

    // ---------------- stage 7: second translation, saturated entries
    t_word              r7_ent [4][4];
    logic               r7_ok;
    logic               r7_vld;
    logic signed [39:0] w7_t1;

    assign w7_t1 = rnd(-(68'(r6_ve[0]) + 68'(r6_ve[1]) + 68'(r6_ve[2])));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r7_ent[k][0] <= r6_ok ? sat(40'(r6_u[k])) : '0;
                r7_ent[k][1] <= r6_ok ? sat(40'(r6_v[k])) : '0;
                r7_ent[k][2] <= r6_ok ? sat(-40'(r6_n[k])) : '0;
                r7_ent[k][3] <= '0;
            end
            r7_ent[3][0] <= r6_ok ? sat(r6_t0) : '0;
            r7_ent[3][1] <= r6_ok ? sat(w7_t1) : '0;
            r7_ent[3][2] <= r6_ok ? sat(r6_t2) : '0;
            r7_ent[3][3] <= r6_ok ? sat(40'sd1 <<< FRAC_BITS) : '0;
            r7_ok        <= r6_ok;
        end
    end

    // ---------------- valid bits of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            for (int s = 0; s < L; s++) r_dl_vld[s] <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld      <= s_axis_tvalid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r_dl_vld[0] <= r3_vld;
            for (int s = 1; s < L; s++) r_dl_vld[s] <= r_dl_vld[s-1];
            r4_vld      <= r_dl_vld[L-1];
            r5_vld      <= r4_vld;
            r6_vld      <= r5_vld;
            r7_vld      <= r6_vld;
        end
    end

    // ---------------- column output register
    t_word      r_s_ent [4][4];
    logic       r_s_degen;
    logic       r_s_vld;
    logic [1:0] r_col;

    // the pipeline moves when the output is empty or its last column leaves
    assign w_adv         = !r_s_vld || (m_axis_tready && r_col == LAV_LAST_COL);
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_col   <= '0;
        end else if (w_adv) begin
            r_s_vld <= r7_vld;
            r_col   <= '0;
        end else if (m_axis_tready) begin
            r_col <= r_col + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_ent   <= r7_ent;
            r_s_degen <= !r7_ok;
        end
    end

    assign m_axis_tvalid = r_s_vld;
    assign m_axis_tdata  = {r_s_ent[r_col][3], r_s_ent[r_col][2],
                            r_s_ent[r_col][1], r_s_ent[r_col][0]};
    assign m_axis_tuser  = {r_s_degen, r_col};
    assign m_axis_tlast  = (r_col == LAV_LAST_COL);

endmodule

### design/lav_norm.sv
// ============================================================================
// lav_norm
// Pipelined vector normalizer: block scaling, sum of squares, digit-by-digit
// square root and three restoring dividers, four steps per stage.
// ============================================================================
module lav_norm
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = LAV_FRAC_BITS,
    parameter int MAG_W     = 64
)(
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [MAG_W-1:0]            i_mag [3],
    input  logic [2:0]                  i_neg,
    output logic signed [FRAC_BITS+1:0] o_unit [3],
    output logic                        o_nz
);

    localparam int NW      = LAV_NORM_W;
    localparam int PW      = $clog2(MAG_W);
    localparam int SQ      = LAV_SQ_STG;
    localparam int DIV_STG = lav_div_stg(FRAC_BITS);
    localparam int DS      = DIV_STG * LAV_STEPS;
    localparam int NUM_W   = NW + FRAC_BITS + 1;
    localparam int QW      = FRAC_BITS + 1;
    localparam int UW      = FRAC_BITS + 2;

    // stage 1: largest magnitude
    logic [MAG_W-1:0] n1_mx;
    logic [MAG_W-1:0] r1_m [3];
    logic [MAG_W-1:0] r1_mx;
    logic [2:0]       r1_neg;

    always_comb begin
        n1_mx = i_mag[0];
        if (i_mag[1] > n1_mx) n1_mx = i_mag[1];
        if (i_mag[2] > n1_mx) n1_mx = i_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m   <= i_mag;
            r1_mx  <= n1_mx;
            r1_neg <= i_neg;
        end
    end

    // stage 2: leading one position
    logic [PW-1:0]    n2_pos;
    logic [MAG_W-1:0] r2_m [3];
    logic [PW-1:0]    r2_pos;
    logic [2:0]       r2_neg;
    logic             r2_nz;

    always_comb begin
        n2_pos = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (r1_mx[b]) n2_pos = PW'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_m   <= r1_m;
            r2_pos <= n2_pos;
            r2_neg <= r1_neg;
            r2_nz  <= |r1_mx;
        end
    end

    // stage 3: common shift so the largest lands in [2^29, 2^30)
    logic [MAG_W+NW-1:0] w3_ext [3];
    logic [NW-1:0]       r3_m [3];
    logic [2:0]          r3_neg;
    logic                r3_nz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w3_ext[i] = {{NW{1'b0}}, r2_m[i]};
            if (r2_pos > PW'(NW-1)) begin
                w3_ext[i] = w3_ext[i] >> (r2_pos - PW'(NW-1));
            end else begin
                w3_ext[i] = w3_ext[i] << (PW'(NW-1) - r2_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r3_m[i] <= w3_ext[i][NW-1:0];
            r3_neg <= r2_neg;
            r3_nz  <= r2_nz;
        end
    end

    // stage 4: squares
    logic [2*NW-1:0] r4_sq [3];
    logic [NW-1:0]   r4_m [3];
    logic [2:0]      r4_neg;
    logic            r4_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r4_sq[i] <= r3_m[i] * r3_m[i];
            r4_m   <= r3_m;
            r4_neg <= r3_neg;
            r4_nz  <= r3_nz;
        end
    end

    // stage 5 and root stages: remainder, partial root, remaining radicand bits
    logic [34:0]   r_sq_rem  [SQ+1];
    logic [31:0]   r_sq_root [SQ+1];
    logic [63:0]   r_sq_s    [SQ+1];
    logic [NW-1:0] r_sq_m    [SQ+1][3];
    logic [2:0]    r_sq_neg  [SQ+1];
    logic          r_sq_nz   [SQ+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_s[0]    <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
            r_sq_m[0]    <= r4_m;
            r_sq_neg[0]  <= r4_neg;
            r_sq_nz[0]   <= r4_nz;
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sq
        logic [34:0] c_rem;
        logic [31:0] c_root;
        logic [63:0] c_s;

        // two radicand bits per step, one root bit out
        always_comb begin
            c_rem  = r_sq_rem[j];
            c_root = r_sq_root[j];
            c_s    = r_sq_s[j];
            for (int k = 0; k < LAV_STEPS; k++) begin
                c_rem = {c_rem[32:0], c_s[63:62]};
                c_s   = {c_s[61:0], 2'b00};
                if (c_rem >= {1'b0, c_root, 2'b01}) begin
                    c_rem  = c_rem - {1'b0, c_root, 2'b01};
                    c_root = {c_root[30:0], 1'b1};
                end else begin
                    c_root = {c_root[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[j+1]  <= c_rem;
                r_sq_root[j+1] <= c_root;
                r_sq_s[j+1]    <= c_s;
                r_sq_m[j+1]    <= r_sq_m[j];
                r_sq_neg[j+1]  <= r_sq_neg[j];
                r_sq_nz[j+1]   <= r_sq_nz[j];
            end
        end
    end

    // divider setup: numerator m*2^F + floor(r/2)
    logic [NUM_W-1:0] w_num [3];
    logic [NUM_W-1:0] w_num_hi [3];
    logic [30:0]      r_dv_rem [DIV_STG+1][3];
    logic [DS-1:0]    r_dv_low [DIV_STG+1][3];
    logic [DS-1:0]    r_dv_q   [DIV_STG+1][3];
    logic [30:0]      r_dv_r   [DIV_STG+1];
    logic [2:0]       r_dv_neg [DIV_STG+1];
    logic             r_dv_nz  [DIV_STG+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i]    = NUM_W'({r_sq_m[SQ][i], {FRAC_BITS{1'b0}}})
                        + NUM_W'(r_sq_root[SQ][30:1]);
            w_num_hi[i] = w_num[i] >> DS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= w_num_hi[i][30:0];
                r_dv_low[0][i] <= w_num[i][DS-1:0];
                r_dv_q[0][i]   <= '0;
            end
            r_dv_r[0]   <= r_sq_root[SQ][30:0];
            r_dv_neg[0] <= r_sq_neg[SQ];
            r_dv_nz[0]  <= r_sq_nz[SQ];
        end
    end

    for (genvar j = 0; j < DIV_STG; j++) begin : g_dv
        logic [31:0]   c_t   [3];
        logic [30:0]   c_rem [3];
        logic [DS-1:0] c_low [3];
        logic [DS-1:0] c_q   [3];

        // restoring division, one quotient bit per step
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                c_rem[i] = r_dv_rem[j][i];
                c_low[i] = r_dv_low[j][i];
                c_q[i]   = r_dv_q[j][i];
                c_t[i]   = '0;
                for (int k = 0; k < LAV_STEPS; k++) begin
                    c_t[i]   = {c_rem[i], c_low[i][DS-1]};
                    c_low[i] = {c_low[i][DS-2:0], 1'b0};
                    if (c_t[i] >= {1'b0, r_dv_r[j]}) begin
                        c_t[i] = c_t[i] - {1'b0, r_dv_r[j]};
                        c_q[i] = {c_q[i][DS-2:0], 1'b1};
                    end else begin
                        c_q[i] = {c_q[i][DS-2:0], 1'b0};
                    end
                    c_rem[i] = c_t[i][30:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[j+1] <= c_rem;
                r_dv_low[j+1] <= c_low;
                r_dv_q[j+1]   <= c_q;
                r_dv_r[j+1]   <= r_dv_r[j];
                r_dv_neg[j+1] <= r_dv_neg[j];
                r_dv_nz[j+1]  <= r_dv_nz[j];
            end
        end
    end

    // apply signs
    logic signed [UW-1:0] n_unit [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_unit[i] = $signed({1'b0, r_dv_q[DIV_STG][i][QW-1:0]});
            if (r_dv_neg[DIV_STG][i]) n_unit[i] = -n_unit[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_unit <= n_unit;
            o_nz   <= r_dv_nz[DIV_STG];
        end
    end

endmodule

### design/lav_chk.sv
// ============================================================================
// lav_chk
// Port-level checks of the view matrix column stream.
// ============================================================================
module lav_chk
    import lav_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [LAV_OUT_W-1:0]  m_axis_tdata,
    input logic [LAV_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    // last marker sits exactly on the translation column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == LAV_LAST_COL)))
        else $error("tlast does not match the column index");

    // columns of one matrix follow without a gap, in order
    a_col_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser[1:0] == $past(m_axis_tuser[1:0]) + 2'd1))
        else $error("column sequence broken");

    // no input word is taken while a matrix is still going out
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken in the middle of a matrix");

    // a degenerate basis gives an all-zero column
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0))
        else $error("degenerate column carries nonzero data");

    // stalled output word holds
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed under stall");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for look_at_view_matrix: cameras go in on the input
// stream, four column words per camera are compared field by field against
// an in-bench fixed-point model of the view basis and translation.
// ============================================================================
module tb_top;
    import lav_pkg::*;

    localparam int IDLE_MAX    = 18;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    typedef t_word t_cam[9];

    typedef struct {
        logic [1:0]  col;
        logic [31:0] row[4];
        logic        degen;
        logic        last;
    } t_column;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [LAV_IN_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [LAV_OUT_W-1:0]  m_axis_tdata;
    logic [LAV_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    t_column column_q[$];
    int      mismatches;
    int      stall_cnt;
    bit      hold_req;

    look_at_view_matrix dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // fixed-point view matrix model
    // ------------------------------------------------------------------
    function automatic logic [63:0] isqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // unit vector from sign and magnitude; ok low for a zero vector
    task automatic unit_vec(input bit neg[3], input logic [63:0] mag[3],
                            output longint o[3], output bit ok);
        logic [63:0] m[3];
        logic [63:0] mx, s, r, q;
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        ok = (mx != 0);
        for (int i = 0; i < 3; i++) begin
            m[i] = mag[i];
            o[i] = 0;
        end
        if (ok) begin
            while (mx >= (64'd1 << 30)) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            r = isqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << LAV_FRAC_BITS) + (r >> 1)) / r;
                o[i] = neg[i] ? -longint'(q) : longint'(q);
            end
        end
    endtask

    function automatic longint round_frac(input longint x);
        logic [63:0] mag, q;
        mag = (x < 0) ? -x : x;
        q = (mag + (64'd1 << (LAV_FRAC_BITS - 1))) >> LAV_FRAC_BITS;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp_word(input longint x);
        longint hi, lo;
        hi = (longint'(1) << (LAV_WORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[31:0];
    endfunction

    task automatic cross_term(input longint p, input longint q,
                              output bit neg, output logic [63:0] mag);
        neg = (p < q);
        mag = neg ? (q - p) : (p - q);
    endtask

    // predict the four column words of one camera and queue them
    task automatic predict_columns(input t_cam c);
        longint e[3], d[3], up[3], n[3], u[3], v[3], t[3];
        longint ent[4][4];
        bit dneg[3], cneg[3];
        logic [63:0] dmag[3], cmag[3];
        bit ok_n, ok_u, ok;
        t_column w;
        for (int i = 0; i < 3; i++) begin
            e[i] = longint'(c[i]);
            d[i] = longint'(c[3 + i]) - e[i];
            up[i] = longint'(c[6 + i]);
            dneg[i] = d[i] < 0;
            dmag[i] = dneg[i] ? -d[i] : d[i];
        end
        cross_term(d[1] * up[2], d[2] * up[1], cneg[0], cmag[0]);
        cross_term(d[2] * up[0], d[0] * up[2], cneg[1], cmag[1]);
        cross_term(d[0] * up[1], d[1] * up[0], cneg[2], cmag[2]);
        unit_vec(dneg, dmag, n, ok_n);
        unit_vec(cneg, cmag, u, ok_u);
        ok = ok_n && ok_u;
        v[0] = round_frac(u[1] * n[2] - u[2] * n[1]);
        v[1] = round_frac(u[2] * n[0] - u[0] * n[2]);
        v[2] = round_frac(u[0] * n[1] - u[1] * n[0]);
        t[0] = round_frac(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]));
        t[1] = round_frac(-(v[0] * e[0] + v[1] * e[1] + v[2] * e[2]));
        t[2] = round_frac(n[0] * e[0] + n[1] * e[1] + n[2] * e[2]);
        for (int k = 0; k < 3; k++) begin
            ent[k][0] = u[k];
            ent[k][1] = v[k];
            ent[k][2] = -n[k];
            ent[k][3] = 0;
        end
        for (int i = 0; i < 3; i++) ent[3][i] = t[i];
        ent[3][3] = longint'(1) << LAV_FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
            w.col = k[1:0];
            for (int i = 0; i < 4; i++) w.row[i] = ok ? clamp_word(ent[k][i]) : 32'd0;
            w.degen = !ok;
            w.last = (k[1:0] == LAV_LAST_COL);
            column_q.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_camera(input t_cam c, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        for (int i = 0; i < 9; i++) s_axis_tdata[i*LAV_FIELD_W +: LAV_FIELD_W] = c[i];
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_columns(c);
    endtask

    task automatic send_idle_gap(input t_cam c);
        send_camera(c, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX));
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 4))
            0: return t_word'($urandom);
            1: return t_word'(int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
            2: return t_word'(int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
            3: return t_word'($urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                                  : 32'h8000_0000 + $urandom_range(0, 255));
            default: return t_word'(int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    function automatic t_cam rand_camera();
        t_cam c;
        int k;
        for (int i = 0; i < 9; i++) c[i] = rand_word();
        case ($urandom_range(0, 15))
            // eye on the target
            0: for (int i = 0; i < 3; i++) c[3 + i] = c[i];
            // up along the view direction, small lengths keep it exact
            1: begin
                k = $urandom_range(1, 4) * ($urandom_range(0, 1) ? 1 : -1);
                for (int i = 0; i < 3; i++) begin
                    c[i] = t_word'(int'($urandom_range(0, 16'hFFFF)) - 32'sh8000);
                    c[3 + i] = t_word'(int'($urandom_range(0, 16'hFFFF)) - 32'sh8000);
                    c[6 + i] = (c[3 + i] - c[i]) * k;
                end
            end
            2: for (int i = 6; i < 9; i++) c[i] = 0;
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // output side: ready with random gaps and a long hold on request
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 2) != 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, IDLE_MAX)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // column word check
    always @(posedge i_clk) begin
        t_column w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (column_q.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_axis_tuser), 32'd0);
            end else begin
                w = column_q.pop_front();
                if (m_axis_tuser[1:0] !== w.col)
                    report_mismatch("column_index", 32'(m_axis_tuser[1:0]), 32'(w.col));
                for (int i = 0; i < 4; i++)
                    if (m_axis_tdata[i*32 +: 32] !== w.row[i])
                        report_mismatch($sformatf("col %0d row %0d", w.col, i),
                                        m_axis_tdata[i*32 +: 32], w.row[i]);
                if (m_axis_tuser[2] !== w.degen)
                    report_mismatch("degenerate", 32'(m_axis_tuser[2]), 32'(w.degen));
                if (m_axis_tlast !== w.last)
                    report_mismatch("last_column", 32'(m_axis_tlast), 32'(w.last));
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        t_cam c;
        t_word mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        // standard camera at z=5 looking at the origin
        c = '{0, 0, 32'sh0005_0000, 0, 0, 0, 0, 32'sh0001_0000, 0};
        send_idle_gap(c);
        // eye on the target
        c = '{32'sh0001_2345, -32'sh0000_5000, 7, 32'sh0001_2345, -32'sh0000_5000, 7,
              0, 32'sh0001_0000, 0};
        send_idle_gap(c);
        // zero up vector
        c = '{0, 0, 0, 32'sh0001_0000, 0, 0, 0, 0, 0};
        send_idle_gap(c);
        // up parallel to the view direction, then a small-integer camera
        c = '{0, 0, 0, 0, 32'sh0003_0000, 0, 0, 32'sh0001_0000, 0};
        send_idle_gap(c);
        c = '{1, 2, 3, 3, 6, 9, -4, -8, -8};
        send_idle_gap(c);
        // all zero
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_idle_gap(c);
        // field extremes: widest differences, large translations
        c = '{mn, mn, mn, mx, mx, mx, mx, mn, mx};
        send_idle_gap(c);
        c = '{mx, mx, mx, mn, mn, mn, mn, mx, mn};
        send_idle_gap(c);
        c = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
        send_idle_gap(c);
        c = '{mn, mx, 0, mx, mn, -1, 1, -1, mx};
        send_idle_gap(c);
        c = '{-1, -1, -1, 0, 0, 0, mn, mn, 1};
        send_idle_gap(c);
        // tiny offsets and tiny up hint
        c = '{0, 0, 0, 1, 0, 0, 0, 0, 1};
        send_idle_gap(c);
        c = '{mx, mx, mx, mx - 1, mx, mx, 0, 1, 0};
        send_idle_gap(c);
        c = '{32'sh1000_0000, -32'sh2000_0000, 32'sh3000_0000, 0, 0, 0, 1, 1, 1};
        send_idle_gap(c);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_idle_gap(rand_camera());
    endtask

    // output held off while input keeps coming, so the pipe backs up
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) send_camera(rand_camera(), 0);
    endtask

    initial begin
        mismatches = 0;
        stall_cnt = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(120);
        test_backpressure();
        test_random(120);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (column_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

### sim.f
design/lav_pkg.sv
design/lav_norm.sv
design/look_at_view_matrix.sv
design/lav_chk.sv
tb/tb_top.sv
